// ===== hw/rtl/assert_macros.svh =====
// Assertion helpers shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/mrac_pkg.sv =====
package mrac_pkg;

    // Field widths of the item channels
    localparam int OP_W     = 2;
    localparam int START_W  = 48;
    localparam int LEN_W    = 32;
    localparam int MASK_W   = 8;
    localparam int STATUS_W = 2;

    // Defaults for the top-level parameters
    localparam int TABLE_ENTRIES_DEF = 16;
    localparam int ADDRESS_BITS_DEF  = 48;

    // Operation codes
    localparam logic [OP_W-1:0] OP_ADD    = 2'd0;
    localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
    localparam logic [OP_W-1:0] OP_CHECK  = 2'd2;

    // Result codes
    localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_MISS = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;
    localparam logic [STATUS_W-1:0] ST_DUP  = 2'd3;

    // Controller to datapath commands
    typedef struct packed {
        logic load;    // capture the input item, restart the scan
        logic step;    // advance the table scan
        logic finish;  // update the table, load the result register
    } ctrl_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic scan_done;  // every entry has been compared
    } dp_stat_t;

endpackage

// ===== hw/rtl/mrac_in_if.sv =====
interface mrac_in_if;
    logic                        valid;
    logic                        ready;
    logic [mrac_pkg::OP_W-1:0]    operation;
    logic [mrac_pkg::START_W-1:0] region_start;
    logic [mrac_pkg::LEN_W-1:0]   region_length;
    logic [mrac_pkg::MASK_W-1:0]  access_mask;

    modport source (
        output valid, operation, region_start, region_length, access_mask,
        input  ready
    );
    modport sink (
        input  valid, operation, region_start, region_length, access_mask,
        output ready
    );
endinterface

// ===== hw/rtl/mrac_out_if.sv =====
interface mrac_out_if;
    logic                          valid;
    logic                          ready;
    logic [mrac_pkg::STATUS_W-1:0] status;

    modport source (
        output valid, status,
        input  ready
    );
    modport sink (
        input  valid, status,
        output ready
    );
endinterface

// ===== hw/rtl/mrac_ram.sv =====
module mrac_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                 clk,
    input  logic                                 wr_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                     wr_data,
    input  logic                                 rd_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                     rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write one word, read one word registered
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hw/rtl/mrac_ctrl.sv =====
`include "assert_macros.svh"

module mrac_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    output logic                 out_valid,
    input  logic                 out_ready,
    output mrac_pkg::ctrl_cmd_t  cmd,
    input  mrac_pkg::dp_stat_t   stat
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_DONE = 3'b100
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    // Decode commands from the state and the handshakes
    always_comb
    begin
        in_ready   = (state_reg == S_IDLE);
        cmd.load   = (state_reg == S_IDLE) && in_valid;
        cmd.step   = (state_reg == S_SCAN);
        cmd.finish = (state_reg == S_DONE) && (!out_valid_reg || out_ready);
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (cmd.load)
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (stat.scan_done)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (cmd.finish)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold the result until taken, set it when a new one is loaded
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.finish)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

    `ASSERT_NEXT(a_finish_shows_result, clk, rst_n, cmd.finish,
        out_valid_reg && (state_reg == S_IDLE), "finished item shows no result")
    `ASSERT_IMPLIES(a_no_overwrite, clk, rst_n, out_valid_reg && !out_ready,
        !cmd.finish, "result overwritten while still waiting")

endmodule

// ===== hw/rtl/mrac_dpath.sv =====
`include "assert_macros.svh"

module mrac_dpath #(
    parameter int TABLE_ENTRIES = mrac_pkg::TABLE_ENTRIES_DEF,
    parameter int ADDRESS_BITS  = mrac_pkg::ADDRESS_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  mrac_pkg::ctrl_cmd_t           cmd,
    output mrac_pkg::dp_stat_t            stat,
    input  logic [mrac_pkg::OP_W-1:0]     operation,
    input  logic [mrac_pkg::START_W-1:0]  region_start,
    input  logic [mrac_pkg::LEN_W-1:0]    region_length,
    input  logic [mrac_pkg::MASK_W-1:0]   access_mask,
    output logic [mrac_pkg::STATUS_W-1:0] status
);

    localparam int ABITS = (ADDRESS_BITS < mrac_pkg::START_W) ? ADDRESS_BITS
                                                               : mrac_pkg::START_W;
    localparam int EBITS = ((ABITS > mrac_pkg::LEN_W) ? ABITS : mrac_pkg::LEN_W) + 1;
    localparam int IDXW  = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CNTW  = $clog2(TABLE_ENTRIES + 1);
    localparam int ENT_W = ABITS + mrac_pkg::LEN_W + mrac_pkg::MASK_W;
    localparam logic [CNTW-1:0] LAST_CNT = CNTW'(TABLE_ENTRIES);

    // Captured item
    logic [mrac_pkg::OP_W-1:0]    op_reg;
    logic [ABITS-1:0]             start_reg;
    logic [mrac_pkg::LEN_W-1:0]   len_reg;
    logic [mrac_pkg::MASK_W-1:0]  mask_reg;
    logic [EBITS-1:0]             end_reg;
    logic [mrac_pkg::STATUS_W-1:0] status_reg;
    logic [mrac_pkg::STATUS_W-1:0] status_next;

    // Scan state
    logic [CNTW-1:0] rd_cnt_reg;
    logic            cmp_vld_reg;
    logic [IDXW-1:0] cmp_idx_reg;
    logic            match_found_reg;
    logic [IDXW-1:0] match_idx_reg;
    logic            free_found_reg;
    logic [IDXW-1:0] free_idx_reg;
    logic            valid_reg [TABLE_ENTRIES];

    // Table memory port signals
    logic             rd_en;
    logic [IDXW-1:0]  rd_addr;
    logic [ENT_W-1:0] rd_data;
    logic             wr_en;
    logic [ENT_W-1:0] wr_data;

    // Entry fields and compare results
    logic [ABITS-1:0]            ent_base;
    logic [mrac_pkg::LEN_W-1:0]  ent_size;
    logic [mrac_pkg::MASK_W-1:0] ent_perm;
    logic [EBITS-1:0]            ent_end;
    logic                        ent_valid;
    logic                        hit;
    logic                        add_ok;
    logic                        remove_ok;

    mrac_ram #(
        .WIDTH (ENT_W),
        .DEPTH (TABLE_ENTRIES)
    ) u_table (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (free_idx_reg),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Issue one table read per scan cycle
    assign rd_en   = cmd.step && (rd_cnt_reg != LAST_CNT);
    assign rd_addr = rd_cnt_reg[IDXW-1:0];
    assign stat.scan_done = (rd_cnt_reg == LAST_CNT) && !cmp_vld_reg;

    // Compare the entry read in the previous cycle
    always_comb
    begin
        ent_base  = rd_data[ENT_W-1 -: ABITS];
        ent_size  = rd_data[mrac_pkg::MASK_W +: mrac_pkg::LEN_W];
        ent_perm  = rd_data[mrac_pkg::MASK_W-1:0];
        ent_end   = EBITS'(ent_base) + EBITS'(ent_size);
        ent_valid = valid_reg[cmp_idx_reg];
        case (op_reg)
            mrac_pkg::OP_ADD:
            begin
                hit = ent_valid && (ent_base == start_reg);
            end
            mrac_pkg::OP_REMOVE:
            begin
                hit = ent_valid && (ent_base == start_reg) && (ent_perm == mask_reg);
            end
            mrac_pkg::OP_CHECK:
            begin
                hit = ent_valid && (start_reg >= ent_base) && (end_reg <= ent_end)
                      && ((ent_perm & mask_reg) == mask_reg);
            end
            default:
            begin
                hit = 1'b0;
            end
        endcase
    end

    // Pick the result once the scan is over
    always_comb
    begin
        add_ok    = (op_reg == mrac_pkg::OP_ADD) && !match_found_reg && free_found_reg;
        remove_ok = (op_reg == mrac_pkg::OP_REMOVE) && match_found_reg;
        case (op_reg)
            mrac_pkg::OP_ADD:
            begin
                if (match_found_reg)
                begin
                    status_next = mrac_pkg::ST_DUP;
                end
                else if (!free_found_reg)
                begin
                    status_next = mrac_pkg::ST_FULL;
                end
                else
                begin
                    status_next = mrac_pkg::ST_OK;
                end
            end
            mrac_pkg::OP_REMOVE, mrac_pkg::OP_CHECK:
            begin
                status_next = match_found_reg ? mrac_pkg::ST_OK : mrac_pkg::ST_MISS;
            end
            default:
            begin
                status_next = mrac_pkg::ST_MISS;
            end
        endcase
    end

    assign wr_en   = cmd.finish && add_ok;
    assign wr_data = {start_reg, len_reg, mask_reg};

    // Scan control, first-match tracking and valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_cnt_reg      <= '0;
            cmp_vld_reg     <= 1'b0;
            match_found_reg <= 1'b0;
            free_found_reg  <= 1'b0;
            for (int i = 0; i < TABLE_ENTRIES; i++)
            begin
                valid_reg[i] <= 1'b0;
            end
        end
        else
        begin
            cmp_vld_reg <= rd_en;
            if (cmd.load)
            begin
                rd_cnt_reg      <= '0;
                match_found_reg <= 1'b0;
                free_found_reg  <= 1'b0;
            end
            else
            begin
                if (rd_en)
                begin
                    rd_cnt_reg <= rd_cnt_reg + CNTW'(1);
                end
                if (cmp_vld_reg && hit && !match_found_reg)
                begin
                    match_found_reg <= 1'b1;
                end
                if (cmp_vld_reg && !ent_valid && !free_found_reg)
                begin
                    free_found_reg <= 1'b1;
                end
            end
            if (cmd.finish && add_ok)
            begin
                valid_reg[free_idx_reg] <= 1'b1;
            end
            if (cmd.finish && remove_ok)
            begin
                valid_reg[match_idx_reg] <= 1'b0;
            end
        end
    end

    // Item capture, indexes and result payload
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg    <= operation;
            start_reg <= region_start[ABITS-1:0];
            len_reg   <= region_length;
            mask_reg  <= access_mask;
            end_reg   <= EBITS'(region_start[ABITS-1:0]) + EBITS'(region_length);
        end
        if (rd_en)
        begin
            cmp_idx_reg <= rd_addr;
        end
        if (cmp_vld_reg && hit && !match_found_reg)
        begin
            match_idx_reg <= cmp_idx_reg;
        end
        if (cmp_vld_reg && !ent_valid && !free_found_reg)
        begin
            free_idx_reg <= cmp_idx_reg;
        end
        if (cmd.finish)
        begin
            status_reg <= status_next;
        end
    end

    assign status = status_reg;

    `ASSERT_IMPLIES(a_remove_hits_valid, clk, rst_n, cmd.finish && remove_ok,
        valid_reg[match_idx_reg], "remove clears an entry that is not valid")
    `ASSERT_IMPLIES(a_add_into_free, clk, rst_n, cmd.finish && add_ok,
        !valid_reg[free_idx_reg], "add overwrites a valid entry")

endmodule

// ===== hw/rtl/memory_region_access_checker.sv =====
// Channel | dir | item contents
// req     | in  | operation, region_start, region_length, access_mask
// rsp     | out | status
//
// Each item is scanned against the whole table before its result is loaded:
// the table memory is scanned one entry per cycle through its single read port.
// A new item is accepted only when the previous one has loaded its result.
// rst_n clears all valid bits at once; stored regions need no clearing pass.
// A stalled rsp holds its status; a finished item waits until rsp is free.
module memory_region_access_checker #(
    parameter int TABLE_ENTRIES = mrac_pkg::TABLE_ENTRIES_DEF,
    parameter int ADDRESS_BITS  = mrac_pkg::ADDRESS_BITS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    mrac_in_if.sink           req,
    mrac_out_if.source        rsp
);

    mrac_pkg::ctrl_cmd_t cmd;
    mrac_pkg::dp_stat_t  stat;

    mrac_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .cmd       (cmd),
        .stat      (stat)
    );

    mrac_dpath #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .ADDRESS_BITS  (ADDRESS_BITS)
    ) u_dpath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .operation     (req.operation),
        .region_start  (req.region_start),
        .region_length (req.region_length),
        .access_mask   (req.access_mask),
        .status        (rsp.status)
    );

endmodule
